// ===== rtl/core/crc16m_pkg.sv =====
package crc16m_pkg;

    // frame length as set for this build, and the value actually used
    localparam int FRAME_BYTES = 8;
    localparam int FRAME_LEN   = (FRAME_BYTES < 1) ? 1 :
                                 ((FRAME_BYTES > 255) ? 255 : FRAME_BYTES);

    // byte counter width, at least one bit
    localparam int CNT_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [CNT_W-1:0] t_count;

    // fold one byte into the crc, lsb first, eight shift steps
    function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc16_modbus_frame_appender.sv =====
// crc16_modbus_frame_appender
// Input channel: i_valid / o_ready with payload i_data_byte, one byte per item.
// Output channel: o_valid / i_ready with o_out_byte and o_frame_end.
// Every input byte is passed on unchanged while it is folded into a running
// CRC-16/MODBUS. After the last byte of a frame (FRAME_BYTES in the package)
// two more items follow: the crc low byte, then the crc high byte with
// o_frame_end set; crc and byte count then restart for the next frame.
// Path: an accepted byte is registered in the input register, then moves to
// the output register when that is free and no crc byte waits; o_out_byte shows it.
// Throughput: one byte per cycle inside a frame while i_ready stays high; the
// two crc items pass through the output register first, holding the input byte.
// The output register is the limit: one item leaves per cycle while i_ready is high.
// Reset: synchronous, active low; clears both registers' valid flags, the
// pending crc items, the crc (to 0xFFFF) and the byte count.
// Stall: while i_ready is low the output item holds; the input register
// still takes one more byte, then o_ready drops until the output moves.
module crc16_modbus_frame_appender
    import crc16m_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;
    logic        r_pend_lo;
    logic        r_pend_hi;
    logic [15:0] r_pend_crc;

    logic        out_free;
    logic        take_in;
    logic        fold;
    logic [15:0] crc_new;
    logic        crc_last;

    // output register can load when empty or being taken
    assign out_free = !r_out_valid || i_ready;
    // input item moves on when no crc byte is waiting
    assign fold     = out_free && r_in_valid && !r_pend_lo && !r_pend_hi;
    assign o_ready  = !r_in_valid || fold;
    assign take_in  = i_valid && o_ready;

    crc16m_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fold  (fold),
        .i_byte  (r_in_byte),
        .o_crc   (crc_new),
        .o_last  (crc_last)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (take_in) begin
            r_in_byte <= i_data_byte;
        end
    end

    // output register and pending crc bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend_lo   <= 1'b0;
            r_pend_hi   <= 1'b0;
        end else if (out_free) begin
            if (r_pend_lo) begin
                r_out_valid <= 1'b1;
                r_pend_lo   <= 1'b0;
            end else if (r_pend_hi) begin
                r_out_valid <= 1'b1;
                r_pend_hi   <= 1'b0;
            end else if (r_in_valid) begin
                r_out_valid <= 1'b1;
                r_pend_lo   <= crc_last;
                r_pend_hi   <= crc_last;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
        if (out_free) begin
            if (r_pend_lo) begin
                r_out_byte <= r_pend_crc[7:0];
                r_out_end  <= 1'b0;
            end else if (r_pend_hi) begin
                r_out_byte <= r_pend_crc[15:8];
                r_out_end  <= 1'b1;
            end else begin
                r_out_byte <= r_in_byte;
                r_out_end  <= 1'b0;
            end
        end
        if (fold && crc_last) begin
            r_pend_crc <= crc_new;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

endmodule

// ===== rtl/core/crc16m_crc_unit.sv =====
module crc16m_crc_unit
    import crc16m_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fold,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc,
    output logic        o_last
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    t_count      r_count;
    t_count      n_count;

    // crc after this byte, and whether it closes the frame
    assign o_crc  = fold_byte(r_crc, i_byte);
    assign o_last = (r_count == t_count'(FRAME_LEN - 1));

    // next running crc and byte count
    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        if (i_fold) begin
            if (o_last) begin
                n_crc   = CRC_INIT;
                n_count = '0;
            end else begin
                n_crc   = o_crc;
                n_count = r_count + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
        end else begin
            r_crc   <= n_crc;
            r_count <= n_count;
        end
    end

endmodule

// ===== tb/crc16_modbus_frame_appender_tb.sv =====
`timescale 1ns / 100ps

module crc16_modbus_frame_appender_tb;
    import crc16m_pkg::*;

    localparam int RAND_ITEMS   = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    // one byte leaving the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_item;

    // per-item note from the sender: pass-through value typed in or not
    typedef struct packed {
        logic       typed;
        logic [7:0] out_byte;
    } t_pass_note;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [7:0] out_byte;
    } t_stim_row;

    // receiver stall styles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_frame_end;

    t_out_item  bytes_due_q[$];
    t_pass_note pass_note_q[$];

    logic [15:0] frame_crc   = CRC_INIT;
    int          frame_taken = 0;
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    bit          hold_req     = 1'b0;

    // directed frames: edge bytes, all ones, then zeros followed by mixed bytes
    t_stim_row dir_tab [24] = '{
        '{8'h00, 1'b1, 8'h00}, '{8'hFF, 1'b1, 8'hFF}, '{8'h01, 1'b1, 8'h01},
        '{8'h80, 1'b1, 8'h80}, '{8'h7F, 1'b1, 8'h7F}, '{8'hFE, 1'b1, 8'hFE},
        '{8'hAA, 1'b1, 8'hAA}, '{8'h55, 1'b1, 8'h55},
        '{8'hFF, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 8'hFF},
        '{8'hFF, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 8'hFF},
        '{8'hFF, 1'b1, 8'hFF}, '{8'hFF, 1'b1, 8'hFF},
        '{8'h00, 1'b1, 8'h00}, '{8'h00, 1'b1, 8'h00}, '{8'h00, 1'b1, 8'h00},
        '{8'h00, 1'b1, 8'h00}, '{8'h12, 1'b0, 8'h00}, '{8'h9A, 1'b0, 8'h00},
        '{8'hC3, 1'b0, 8'h00}, '{8'h3C, 1'b0, 8'h00}
    };

    crc16_modbus_frame_appender DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // bitwise reflected crc step, one data bit at a time
    function automatic logic [15:0] crc_mix_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // expected bytes for one accepted item, frame state updated
    function automatic void predict_frame_byte(input logic [7:0] b, input t_pass_note note);
        t_out_item pass;
        pass.out_byte  = note.typed ? note.out_byte : b;
        pass.frame_end = 1'b0;
        bytes_due_q.push_back(pass);
        frame_crc   = crc_mix_byte(frame_crc, b);
        frame_taken = frame_taken + 1;
        if (frame_taken >= FRAME_LEN) begin
            bytes_due_q.push_back('{frame_crc[7:0], 1'b0});
            bytes_due_q.push_back('{frame_crc[15:8], 1'b1});
            frame_crc   = CRC_INIT;
            frame_taken = 0;
        end
    endfunction

    // accept tracking, prediction and checking, all on the rising edge
    always @(posedge i_clk) begin : monitor
        t_pass_note note;
        t_out_item  want;
        bit         moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                moved = 1'b1;
                note  = '{1'b0, 8'h00};
                if (pass_note_q.size() != 0) begin
                    note = pass_note_q.pop_front();
                end
                predict_frame_byte(i_data_byte, note);
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (bytes_due_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("unexpected item: byte %02h end %0b", o_out_byte, o_frame_end);
                    end
                end else begin
                    want = bytes_due_q.pop_front();
                    if (o_out_byte !== want.out_byte || o_frame_end !== want.frame_end) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                                     want.out_byte, want.frame_end, o_out_byte, o_frame_end);
                        end
                    end
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // watchdog on cycles with no item moving
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("FAIL");
        $finish;
    end

    // receiver: stall styles in stretches, plus one long hold-off on request
    initial begin
        t_rx_mode   mode;
        int         left;
        logic [7:0] pat;
        mode = RX_OPEN;
        left = 0;
        pat  = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(20, 80);
                    pat  = 8'($urandom);
                end
                left--;
                case (mode)
                    RX_OPEN: begin
                        i_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    RX_PATTERN: begin
                        i_ready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // offer one item after an optional gap, return once it is taken
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [7:0] typed_out,
                             input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pass_note_q.push_back('{typed, typed_out});
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // sender: reset, directed table, then random bursts
    initial begin
        int         burst_left;
        int         gap;
        logic [7:0] b;
        burst_left = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            send_byte(dir_tab[k].data, dir_tab[k].typed, dir_tab[k].out_byte,
                      (k % 5 == 4) ? 2 : 0);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 150) begin
                hold_req = 1'b1;
            end
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
            burst_left--;
            if (hold_req) begin
                gap = 0;
            end
            // lean on all-zero and all-one bytes now and then
            case ($urandom_range(0, 15))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, 1'b0, 8'h00, gap);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then a few quiet cycles to catch stray items
        while (bytes_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && bytes_due_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/crc16m_pkg.sv
rtl/core/crc16m_crc_unit.sv
rtl/core/crc16_modbus_frame_appender.sv
tb/crc16_modbus_frame_appender_tb.sv
